>>> rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, constants and helpers for the scaled decimal comparator.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int MANT_BITS = 96;
    localparam int MAX_SCALE = 28;
    localparam int SCALE_W   = 5;

    localparam int IN_W      = 96;
    localparam int WORK_W    = 192;
    localparam int LIMB_W    = 32;
    localparam int LIMBS     = WORK_W / LIMB_W;
    localparam int CNT_W     = $clog2(LIMBS);

    // largest power of ten applied in one pass over the limbs
    localparam int CHUNK_MAX = 9;
    localparam int CHUNK_W   = 4;
    localparam int FAC_W     = 30;
    localparam int PROD_W    = LIMB_W + FAC_W;

    localparam logic [IN_W-1:0] MANT_MASK = (IN_W'(1) << MANT_BITS) - IN_W'(1);

    localparam logic signed [1:0] ORD_LT = 2'sb11;
    localparam logic signed [1:0] ORD_EQ = 2'sb00;
    localparam logic signed [1:0] ORD_GT = 2'sb01;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_CMP,
        S_FIN,
        S_HOLD
    } sdc_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic first;
    } sdc_ctl_t;

    typedef logic [LIMBS-1:0][LIMB_W-1:0] sdc_word_t;

    function automatic logic [FAC_W-1:0] pow10(input logic [CHUNK_W-1:0] k);
        logic [FAC_W-1:0] r;
        case (k)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

    function automatic logic [CHUNK_W-1:0] chunk(input logic [SCALE_W-1:0] d);
        logic [CHUNK_W-1:0] r;
        if (d > SCALE_W'(CHUNK_MAX))
            r = CHUNK_W'(CHUNK_MAX);
        else
            r = CHUNK_W'(d);
        return r;
    endfunction

    function automatic logic signed [1:0] ord_neg(input logic signed [1:0] o);
        logic signed [1:0] r;
        case (o)
            ORD_LT:  r = ORD_GT;
            ORD_GT:  r = ORD_LT;
            default: r = ORD_EQ;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/sdc_scaler.sv
// ----------------------------------------------------------------------------
// sdc_scaler
// Limb-serial multiplier: scales a 192-bit mantissa by a small power of ten,
// one 32-bit limb per cycle while ctl.step is set, low limb first, rotating through a shift register.
// ----------------------------------------------------------------------------
module sdc_scaler (
    input  logic                            clk,
    input  sdc_pkg::sdc_ctl_t               ctl,
    input  logic [sdc_pkg::WORK_W-1:0]      load_value,
    input  logic [sdc_pkg::FAC_W-1:0]       factor,
    output logic [sdc_pkg::LIMB_W-1:0]      low_limb
);

    sdc_pkg::sdc_word_t                 sr_reg;
    sdc_pkg::sdc_word_t                 sr_next;
    logic [sdc_pkg::FAC_W-1:0]          carry_reg;
    logic [sdc_pkg::FAC_W-1:0]          carry_next;
    logic [sdc_pkg::FAC_W-1:0]          carry_in;
    logic [sdc_pkg::PROD_W-1:0]         t;

    assign carry_in = ctl.first ? '0 : carry_reg;
    assign t        = sdc_pkg::PROD_W'(sr_reg[0]) * sdc_pkg::PROD_W'(factor)
                    + sdc_pkg::PROD_W'(carry_in);
    assign low_limb = sr_reg[0];

    always_comb
    begin
        sr_next    = sr_reg;
        carry_next = carry_reg;
        if (ctl.load)
        begin
            sr_next = load_value;
        end
        else if (ctl.step)
        begin
            // advance: product limb enters at the top
            sr_next    = {t[sdc_pkg::LIMB_W-1:0], sr_reg[sdc_pkg::LIMBS-1:1]};
            carry_next = t[sdc_pkg::PROD_W-1:sdc_pkg::LIMB_W];
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg    <= sr_next;
        carry_reg <= carry_next;
    end

endmodule

>>> rtl/sdc_limb_cmp.sv
// ----------------------------------------------------------------------------
// sdc_limb_cmp
// Limb-serial magnitude comparator: holds the reference mantissa in a rotating
// shift register and orders it against the scaled limbs, low limb first.
// ----------------------------------------------------------------------------
module sdc_limb_cmp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sdc_pkg::sdc_ctl_t               ctl,
    input  logic [sdc_pkg::WORK_W-1:0]      load_value,
    input  logic [sdc_pkg::LIMB_W-1:0]      x_limb,
    output logic signed [1:0]               mag
);

    sdc_pkg::sdc_word_t     ref_reg;
    sdc_pkg::sdc_word_t     ref_next;
    logic signed [1:0]      mag_reg;
    logic signed [1:0]      mag_next;
    logic signed [1:0]      base;

    assign mag = mag_reg;

    always_comb
    begin
        ref_next = ref_reg;
        mag_next = mag_reg;
        base     = ctl.first ? sdc_pkg::ORD_EQ : mag_reg;
        if (ctl.load)
        begin
            ref_next = load_value;
        end
        else if (ctl.step)
        begin
            ref_next = {ref_reg[0], ref_reg[sdc_pkg::LIMBS-1:1]};
            // higher limbs come later and override
            if (x_limb > ref_reg[0])
                mag_next = sdc_pkg::ORD_GT;
            else if (x_limb < ref_reg[0])
                mag_next = sdc_pkg::ORD_LT;
            else
                mag_next = base;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg <= ref_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mag_reg <= sdc_pkg::ORD_EQ;
        else
            mag_reg <= mag_next;
    end

endmodule

>>> rtl/scaled_decimal_compare.sv
// ----------------------------------------------------------------------------
// scaled_decimal_compare
// Orders two scaled decimals (96-bit mantissa, scale 0..28, sign) as -1/0/+1.
// ----------------------------------------------------------------------------
// One request at a time. With d the difference of the two (saturated) scales,
// a request makes ceil(d/9) scaling passes through a single 32x30-bit limb
// multiplier that applies up to 10^9 per pass over the six 32-bit limbs of the
// 192-bit working value, then a limb-serial compare (S_CMP), a sign fix-up
// (S_FIN) and S_HOLD, which waits for a free output register. Requests where
// both mantissas are zero or the signs differ go straight to S_HOLD. A finished
// result waits in the output register while the next request is taken.
module scaled_decimal_compare (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [63:0]                         a_mant_low,
    input  logic [31:0]                         a_mant_high,
    input  logic [sdc_pkg::SCALE_W-1:0]         a_scale,
    input  logic                                a_negative,
    input  logic [63:0]                         b_mant_low,
    input  logic [31:0]                         b_mant_high,
    input  logic [sdc_pkg::SCALE_W-1:0]         b_scale,
    input  logic                                b_negative,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [1:0]                   order
);

    sdc_pkg::sdc_state_t                state_reg;
    sdc_pkg::sdc_state_t                state_next;
    logic [sdc_pkg::CNT_W-1:0]          cnt_reg;
    logic [sdc_pkg::CNT_W-1:0]          cnt_next;
    logic [sdc_pkg::SCALE_W-1:0]        diff_reg;
    logic [sdc_pkg::SCALE_W-1:0]        diff_next;
    logic [sdc_pkg::FAC_W-1:0]          fac_reg;
    logic [sdc_pkg::FAC_W-1:0]          fac_next;
    logic                               swap_reg;
    logic                               swap_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic signed [1:0]                  res_reg;
    logic signed [1:0]                  res_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [1:0]                  order_reg;
    logic signed [1:0]                  order_next;

    logic [sdc_pkg::IN_W-1:0]           a_m;
    logic [sdc_pkg::IN_W-1:0]           b_m;
    logic [sdc_pkg::SCALE_W-1:0]        sa;
    logic [sdc_pkg::SCALE_W-1:0]        sb;
    logic                               swap_in;
    logic [sdc_pkg::SCALE_W-1:0]        diff_in;
    logic                               out_load;
    logic                               last_limb;
    sdc_pkg::sdc_ctl_t                  sc_ctl;
    sdc_pkg::sdc_ctl_t                  cmp_ctl;
    logic [sdc_pkg::LIMB_W-1:0]         x_limb;
    logic signed [1:0]                  mag;

    assign a_m = {a_mant_high, a_mant_low} & sdc_pkg::MANT_MASK;
    assign b_m = {b_mant_high, b_mant_low} & sdc_pkg::MANT_MASK;
    assign sa  = (a_scale > sdc_pkg::SCALE_W'(sdc_pkg::MAX_SCALE))
               ? sdc_pkg::SCALE_W'(sdc_pkg::MAX_SCALE) : a_scale;
    assign sb  = (b_scale > sdc_pkg::SCALE_W'(sdc_pkg::MAX_SCALE))
               ? sdc_pkg::SCALE_W'(sdc_pkg::MAX_SCALE) : b_scale;
    assign swap_in   = sa > sb;
    assign diff_in   = swap_in ? (sa - sb) : (sb - sa);
    assign last_limb = cnt_reg == sdc_pkg::CNT_W'(sdc_pkg::LIMBS - 1);

    assign out_valid = out_valid_reg;
    assign order     = order_reg;

    sdc_scaler u_scaler (
        .clk        (clk),
        .ctl        (sc_ctl),
        .load_value (sdc_pkg::WORK_W'(swap_in ? b_m : a_m)),
        .factor     (fac_reg),
        .low_limb   (x_limb)
    );

    sdc_limb_cmp u_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cmp_ctl),
        .load_value (sdc_pkg::WORK_W'(swap_in ? a_m : b_m)),
        .x_limb     (x_limb),
        .mag        (mag)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        diff_next  = diff_reg;
        fac_next   = fac_reg;
        swap_next  = swap_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        sc_ctl     = '0;
        cmp_ctl    = '0;
        case (state_reg)
            sdc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sc_ctl.load  = 1'b1;
                    cmp_ctl.load = 1'b1;
                    swap_next    = swap_in;
                    neg_next     = a_negative;
                    cnt_next     = '0;
                    if (a_m == '0 && b_m == '0)
                    begin
                        res_next   = sdc_pkg::ORD_EQ;
                        state_next = sdc_pkg::S_HOLD;
                    end
                    else if (a_negative != b_negative)
                    begin
                        res_next   = a_negative ? sdc_pkg::ORD_LT : sdc_pkg::ORD_GT;
                        state_next = sdc_pkg::S_HOLD;
                    end
                    else if (diff_in == '0)
                    begin
                        fac_next   = sdc_pkg::pow10('0);
                        state_next = sdc_pkg::S_CMP;
                    end
                    else
                    begin
                        fac_next   = sdc_pkg::pow10(sdc_pkg::chunk(diff_in));
                        diff_next  = diff_in - sdc_pkg::SCALE_W'(sdc_pkg::chunk(diff_in));
                        state_next = sdc_pkg::S_SCALE;
                    end
                end
            end
            sdc_pkg::S_SCALE:
            begin
                sc_ctl.step  = 1'b1;
                sc_ctl.first = cnt_reg == '0;
                if (last_limb)
                begin
                    cnt_next = '0;
                    if (diff_reg == '0)
                    begin
                        fac_next   = sdc_pkg::pow10('0);
                        state_next = sdc_pkg::S_CMP;
                    end
                    else
                    begin
                        fac_next  = sdc_pkg::pow10(sdc_pkg::chunk(diff_reg));
                        diff_next = diff_reg - sdc_pkg::SCALE_W'(sdc_pkg::chunk(diff_reg));
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            sdc_pkg::S_CMP:
            begin
                sc_ctl.step   = 1'b1;
                sc_ctl.first  = cnt_reg == '0;
                cmp_ctl.step  = 1'b1;
                cmp_ctl.first = cnt_reg == '0;
                if (last_limb)
                begin
                    cnt_next   = '0;
                    state_next = sdc_pkg::S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            sdc_pkg::S_FIN:
            begin
                // flip once for swapped operands, once for two negatives
                res_next   = (swap_reg ^ neg_reg) ? sdc_pkg::ord_neg(mag) : mag;
                state_next = sdc_pkg::S_HOLD;
            end
            sdc_pkg::S_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sdc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sdc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        order_next     = order_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            order_next     = res_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdc_pkg::S_IDLE;
            cnt_reg       <= '0;
            diff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            diff_reg      <= diff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fac_reg   <= fac_next;
        swap_reg  <= swap_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
        order_reg <= order_next;
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != sdc_pkg::S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> order != 2'sb10)
        else $error("result code outside -1..1");

    a_limb_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sdc_pkg::CNT_W'(sdc_pkg::LIMBS - 1))
        else $error("limb counter beyond last limb");

    a_cmp_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdc_pkg::S_CMP && last_limb) |=> state_reg == sdc_pkg::S_FIN)
        else $error("compare pass did not finish after the last limb");
`endif

endmodule
